// File: rtl/core/dtlv_pkg.sv
// ----------------------------------------------------------------------------
// dtlv_pkg
// Shared widths, defaults and status codes of the DER TLV header parser.
// ----------------------------------------------------------------------------
package dtlv_pkg;

	// field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 4;
	localparam int unsigned KIND_W   = 2;

	// stream payload widths; the data widths are whole bytes
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 80;

	// default count of long-form length bytes and width of their counter
	localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;
	localparam int unsigned LEN_CNT_W            = 3;

	// DER header constants
	localparam logic [7:0] TAG_NUM_MASK = 8'h1F;
	localparam logic [7:0] LEN_LONG_BIT = 8'h80;
	localparam logic [7:0] LEN_CNT_MASK = 8'h7F;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;

	// value kinds sampled at the tag byte
	typedef enum logic [KIND_W-1:0] {
		KIND_PLAIN   = 2'd0,
		KIND_INTEGER = 2'd1,
		KIND_BITSTR  = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 4'd0,
		ST_SHORT         = 4'd1,
		ST_TAG_MISMATCH  = 4'd2,
		ST_HIGH_TAG      = 4'd3,
		ST_INDEFINITE    = 4'd4,
		ST_TOO_MANY_LEN  = 4'd5,
		ST_LEN_PAST_END  = 4'd6,
		ST_NONMINIMAL    = 4'd7,
		ST_VAL_PAST_END  = 4'd8,
		ST_EMPTY_INTEGER = 4'd9,
		ST_BAD_BITSTR    = 4'd10
	} status_t;

endpackage

// File: rtl/core/der_tlv_header_parser_unit.sv
// ----------------------------------------------------------------------------
// der_tlv_header_parser_unit
// Walks a flat run of DER tag-length-value elements one byte per beat and
// reports tag, value offset, value length and status for each element.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one DER byte per beat. tuser[0] opens a new region whose size is
//   the region_length register; that byte is parsed as a tag. match_tag and
//   value_kind are sampled on tag bytes.
//   m_axis: at most one result beat per input beat, in input order.
//   cfg: region_length write channel, always ready; write it only while the
//   block is idle.
// Timing and throughput
//   A byte is taken every cycle while no result is stalled. Its result, if any,
//   is valid in the cycle after the input beat, out of the result register.
//   The rate is set by the parser state update, done combinationally between
//   the input beat and that register.
// Reset and stall
//   Reset clears the parser to idle, region_length to zero and the result
//   valid flag; bytes seen before a region start are dropped. While a result
//   waits with m_axis_tready low, s_axis_tready is low; once the result is
//   taken the next byte can be accepted in the same cycle.
// ----------------------------------------------------------------------------
module der_tlv_header_parser_unit #(
	parameter int unsigned MAX_LENGTH_BYTES = dtlv_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// region_length register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtlv_pkg::WORD_W-1:0]         cfg_data,
	// [7:0] data_byte, [15:8] match_tag
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dtlv_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [0] first_of_region, [2:1] value_kind
	input  logic [dtlv_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] elem_tag, [39:8] value_offset, [71:40] value_length,
	// [75:72] status, [79:76] zero
	output logic [dtlv_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import dtlv_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TAG       = 3'd1,
		PH_LEN0      = 3'd2,
		PH_LEN_FIRST = 3'd3,
		PH_LEN_REST  = 3'd4,
		PH_VAL_FIRST = 3'd5,
		PH_SKIP      = 3'd6,
		PH_ERROR     = 3'd7
	} phase_t;

	// parser state
	phase_t               phase_q;
	logic [WORD_W-1:0]    region_length_q;
	logic [WORD_W-1:0]    bytes_left_q;
	logic [WORD_W-1:0]    byte_pos_q;
	logic [BYTE_W-1:0]    held_tag_q;
	logic [LEN_CNT_W-1:0] len_left_q;
	logic [WORD_W-1:0]    len_accum_q;
	logic [WORD_W-1:0]    skip_q;
	logic [KIND_W-1:0]    held_kind_q;

	// result register
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    res_tag_q;
	logic [WORD_W-1:0]    res_off_q;
	logic [WORD_W-1:0]    res_len_q;
	status_t              res_st_q;

	// input fields
	logic [BYTE_W-1:0]    data_byte;
	logic [BYTE_W-1:0]    match_tag;
	logic                 first_of_region;
	logic [KIND_W-1:0]    value_kind;
	logic                 in_beat;

	assign data_byte       = s_axis_tdata[7:0];
	assign match_tag       = s_axis_tdata[15:8];
	assign first_of_region = s_axis_tuser[0];
	assign value_kind      = s_axis_tuser[2:1];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// next-state values
	phase_t               ph;
	logic [WORD_W-1:0]    bl;
	logic [WORD_W-1:0]    pos;
	logic [WORD_W-1:0]    cur;
	logic [WORD_W-1:0]    was_left;
	logic [BYTE_W-1:0]    tag_n;
	logic [LEN_CNT_W-1:0] len_left_n;
	logic [WORD_W-1:0]    accum_n;
	logic [WORD_W-1:0]    skip_n;
	logic [KIND_W-1:0]    kind_n;
	logic                 hd;
	logic [6:0]           nlen;
	logic [WORD_W:0]      need;
	logic                 emit;
	logic [BYTE_W-1:0]    e_tag;
	logic [WORD_W-1:0]    e_off;
	logic [WORD_W-1:0]    e_len;
	status_t              e_st;

	// one-byte parser step
	always_comb begin
		ph         = phase_q;
		bl         = bytes_left_q;
		pos        = byte_pos_q;
		cur        = byte_pos_q;
		was_left   = bytes_left_q;
		tag_n      = held_tag_q;
		len_left_n = len_left_q;
		accum_n    = len_accum_q;
		skip_n     = skip_q;
		kind_n     = held_kind_q;
		hd         = 1'b0;
		nlen       = data_byte[6:0] & LEN_CNT_MASK[6:0];
		need       = {{(WORD_W-6){1'b0}}, nlen} + 33'd1;
		emit       = 1'b0;
		e_tag      = held_tag_q;
		e_off      = '0;
		e_len      = '0;
		e_st       = ST_OK;

		// region start restarts in any phase
		if (first_of_region) begin
			bl  = region_length_q;
			pos = '0;
			ph  = PH_TAG;
		end

		if (ph != PH_IDLE && ph != PH_ERROR) begin
			cur      = pos;
			was_left = bl;
			pos      = pos + 32'd1;
			if (bl != '0) begin
				bl = bl - 32'd1;
			end

			case (ph)
				PH_TAG: begin
					if (was_left < 32'd2) begin
						emit = 1'b1; e_tag = data_byte; e_st = ST_SHORT; ph = PH_ERROR;
					end else if (match_tag != ZERO_BYTE && data_byte != match_tag) begin
						emit = 1'b1; e_tag = data_byte; e_st = ST_TAG_MISMATCH; ph = PH_ERROR;
					end else if ((data_byte & TAG_NUM_MASK) == TAG_NUM_MASK) begin
						emit = 1'b1; e_tag = data_byte; e_st = ST_HIGH_TAG; ph = PH_ERROR;
					end else begin
						tag_n  = data_byte;
						kind_n = value_kind;
						ph     = PH_LEN0;
					end
				end
				PH_LEN0: begin
					if ((data_byte & LEN_LONG_BIT) == ZERO_BYTE) begin
						accum_n = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
						hd      = 1'b1;
					end else if (data_byte == LEN_LONG_BIT) begin
						emit = 1'b1; e_st = ST_INDEFINITE; ph = PH_ERROR;
					end else if (nlen > 7'(MAX_LENGTH_BYTES)) begin
						emit = 1'b1; e_st = ST_TOO_MANY_LEN; ph = PH_ERROR;
					end else if (need > {1'b0, was_left}) begin
						emit = 1'b1; e_st = ST_LEN_PAST_END; ph = PH_ERROR;
					end else begin
						len_left_n = nlen[LEN_CNT_W-1:0];
						accum_n    = '0;
						ph         = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST, PH_LEN_REST: begin
					if (ph == PH_LEN_FIRST && data_byte == ZERO_BYTE && len_left_q > 3'd1) begin
						emit = 1'b1; e_st = ST_NONMINIMAL; ph = PH_ERROR;
					end else begin
						accum_n = {len_accum_q[WORD_W-BYTE_W-1:0], data_byte};
						if (len_left_q != '0) begin
							len_left_n = len_left_q - 3'd1;
						end
						ph = PH_LEN_REST;
						if (len_left_n == '0) begin
							hd = 1'b1;
						end
					end
				end
				PH_VAL_FIRST: begin
					skip_n = (len_accum_q != '0) ? len_accum_q - 32'd1 : '0;
					if (held_kind_q == KIND_BITSTR && data_byte != ZERO_BYTE) begin
						emit = 1'b1; e_st = ST_BAD_BITSTR; ph = PH_ERROR;
					end else begin
						emit = 1'b1;
						if (held_kind_q == KIND_BITSTR || data_byte == ZERO_BYTE) begin
							e_off = cur + 32'd1;
							e_len = skip_n;
						end else begin
							e_off = cur;
							e_len = len_accum_q;
						end
						if (skip_n == '0) begin
							ph = (bl == '0) ? PH_IDLE : PH_TAG;
						end else begin
							ph = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (skip_q != '0) begin
						skip_n = skip_q - 32'd1;
					end
					if (skip_n == '0) begin
						ph = (bl == '0) ? PH_IDLE : PH_TAG;
					end
				end
				default: begin
					ph = PH_ERROR;
				end
			endcase

			// header complete: check value fits and branch on kind
			if (hd) begin
				if (accum_n > bl) begin
					emit = 1'b1; e_st = ST_VAL_PAST_END; ph = PH_ERROR;
				end else if (held_kind_q == KIND_INTEGER) begin
					if (accum_n == '0) begin
						emit = 1'b1; e_st = ST_EMPTY_INTEGER; ph = PH_ERROR;
					end else if (accum_n == 32'd1) begin
						emit   = 1'b1;
						e_off  = pos;
						e_len  = 32'd1;
						skip_n = 32'd1;
						ph     = PH_SKIP;
					end else begin
						skip_n = accum_n;
						ph     = PH_VAL_FIRST;
					end
				end else if (held_kind_q == KIND_BITSTR) begin
					if (accum_n == '0) begin
						emit = 1'b1; e_st = ST_BAD_BITSTR; ph = PH_ERROR;
					end else begin
						skip_n = accum_n;
						ph     = PH_VAL_FIRST;
					end
				end else begin
					emit   = 1'b1;
					e_off  = pos;
					e_len  = accum_n;
					skip_n = accum_n;
					if (accum_n == '0) begin
						ph = (bl == '0) ? PH_IDLE : PH_TAG;
					end else begin
						ph = PH_SKIP;
					end
				end
			end
		end
	end

	// parser state, config register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			region_length_q <= '0;
			bytes_left_q    <= '0;
			byte_pos_q      <= '0;
			held_tag_q      <= '0;
			len_left_q      <= '0;
			len_accum_q     <= '0;
			skip_q          <= '0;
			held_kind_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				region_length_q <= cfg_data;
			end
			if (in_beat) begin
				phase_q      <= ph;
				bytes_left_q <= bl;
				byte_pos_q   <= pos;
				held_tag_q   <= tag_n;
				len_left_q   <= len_left_n;
				len_accum_q  <= accum_n;
				skip_q       <= skip_n;
				held_kind_q  <= kind_n;
			end
			if (in_beat && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_beat && emit) begin
			res_tag_q <= e_tag;
			res_off_q <= e_off;
			res_len_q <= e_len;
			res_st_q  <= e_st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, res_st_q, res_len_q, res_off_q, res_tag_q};

	// checks
	a_err_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_st_q != ST_OK |-> res_off_q == '0 && res_len_q == '0)
		else $error("error result with nonzero offset or length");

	a_err_goes_error: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && emit && e_st != ST_OK |=> phase_q == PH_ERROR)
		else $error("parser not in error phase after error result");

	a_len_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_left_q <= 3'(MAX_LENGTH_BYTES))
		else $error("length byte count above limit");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("byte taken while result stalled");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives DER byte streams into der_tlv_header_parser_unit and compares every
// element report with a hand-read one or a cycle-free parser model in this file.
// A short hand-checked table opens the run, then random regions follow under
// several region_length settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
	import dtlv_pkg::*;

	// parser phases of the local model
	typedef enum logic [2:0] {
		P_IDLE, P_TAG, P_LEN0, P_LEN_FIRST, P_LEN_REST, P_VAL_FIRST, P_SKIP, P_ERROR
	} parse_phase_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_act_t;

	// value_kind code outside the known kinds, parsed as plain
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [7:0]  tag;
		logic [31:0] val_offset;
		logic [31:0] val_length;
		status_t     status;
	} elem_report_t;

	localparam elem_report_t NO_REPORT = '{8'h00, 32'd0, 32'd0, ST_OK};

	typedef struct packed {
		row_act_t     act;
		logic [31:0]  cfg_value;
		logic [7:0]   data;
		logic         first;
		logic [7:0]   etag;
		logic [1:0]   kind;
		logic         typed;
		elem_report_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [WORD_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// model state of the parser
	logic [31:0]  region_len = '0;
	logic [31:0]  left_cnt = '0;
	logic [31:0]  pos_cnt = '0;
	logic [31:0]  len_acc = '0;
	logic [31:0]  skip_cnt = '0;
	logic [7:0]   held_tag = '0;
	logic [2:0]   len_bytes = '0;
	logic [1:0]   held_kind = '0;
	parse_phase_t cur_phase = P_IDLE;

	elem_report_t pending_reports [$];
	elem_report_t row_want = NO_REPORT;
	bit           row_typed = 1'b0;

	int unsigned byte_beats = 0;
	int unsigned reports_seen = 0;
	int unsigned error_reports = 0;
	int unsigned settings_written = 0;
	int unsigned fault_count = 0;

	// idling control
	bit          calm = 1'b0;
	bit          rx_idle_on = 1'b1;
	bit          tx_idle_on = 1'b1;
	int unsigned window_left = 0;
	int unsigned stall_left = 0;

	// directed table: typed rows carry a hand-read report, the rest use the model
	stim_row_t directed_rows [29] = '{
		'{ROW_BYTE, 32'd0, 8'h30, 1'b1, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h30, 32'd0, 32'd0, ST_SHORT}},
		'{ROW_CFG, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h02, 1'b1, 8'h02, KIND_INTEGER, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h02, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h00, 1'b0, 8'hFF, KIND_UNKNOWN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'hFF, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h03, 1'b0, 8'h00, KIND_BITSTR, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h81, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h01, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h00, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h04, 1'b0, 8'h05, KIND_PLAIN, 1'b1,
			'{8'h04, 32'd0, 32'd0, ST_TAG_MISMATCH}},
		'{ROW_BYTE, 32'd0, 8'h1F, 1'b1, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h1F, 32'd0, 32'd0, ST_HIGH_TAG}},
		'{ROW_BYTE, 32'd0, 8'h05, 1'b1, 8'h00, KIND_UNKNOWN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h80, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h05, 32'd0, 32'd0, ST_INDEFINITE}},
		'{ROW_BYTE, 32'd0, 8'hE0, 1'b1, 8'hE0, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h85, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'hE0, 32'd0, 32'd0, ST_TOO_MANY_LEN}},
		'{ROW_BYTE, 32'd0, 8'hC1, 1'b1, 8'h00, KIND_INTEGER, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h82, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h00, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'hC1, 32'd0, 32'd0, ST_NONMINIMAL}},
		'{ROW_BYTE, 32'd0, 8'h30, 1'b1, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h84, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'hFF, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'hFF, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'hFF, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'hFF, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h30, 32'd0, 32'd0, ST_VAL_PAST_END}},
		'{ROW_CFG, 32'd3, 8'h00, 1'b0, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h05, 1'b1, 8'h00, KIND_PLAIN, 1'b0, NO_REPORT},
		'{ROW_BYTE, 32'd0, 8'h00, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h05, 32'd2, 32'd0, ST_OK}},
		'{ROW_BYTE, 32'd0, 8'h01, 1'b0, 8'h00, KIND_PLAIN, 1'b1,
			'{8'h01, 32'd0, 32'd0, ST_SHORT}}
	};

	der_tlv_header_parser_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic bit fail_elem(input logic [7:0] tag, input status_t st,
			output elem_report_t rep);
		cur_phase = P_ERROR;
		rep = '{tag, 32'd0, 32'd0, st};
		return 1'b1;
	endfunction

	function automatic void goto_next_elem();
		cur_phase = (left_cnt == 0) ? P_IDLE : P_TAG;
	endfunction

	// length known: report now, or wait for the first value byte
	function automatic bit close_header(output elem_report_t rep);
		rep = '{held_tag, pos_cnt, len_acc, ST_OK};
		if (len_acc > left_cnt)
			return fail_elem(held_tag, ST_VAL_PAST_END, rep);
		if (held_kind == KIND_INTEGER) begin
			if (len_acc == 0)
				return fail_elem(held_tag, ST_EMPTY_INTEGER, rep);
			skip_cnt = len_acc;
			if (len_acc == 1) begin
				cur_phase = P_SKIP;
				return 1'b1;
			end
			cur_phase = P_VAL_FIRST;
			return 1'b0;
		end
		if (held_kind == KIND_BITSTR) begin
			if (len_acc == 0)
				return fail_elem(held_tag, ST_BAD_BITSTR, rep);
			skip_cnt = len_acc;
			cur_phase = P_VAL_FIRST;
			return 1'b0;
		end
		skip_cnt = len_acc;
		if (len_acc == 0)
			goto_next_elem();
		else
			cur_phase = P_SKIP;
		return 1'b1;
	endfunction

	// one accepted byte; returns 1 when it produces an element report
	function automatic bit parse_byte(input logic [7:0] b, input logic first,
			input logic [7:0] etag, input logic [1:0] kind, output elem_report_t rep);
		logic [31:0] here;
		logic [31:0] was_left;
		logic [31:0] n_len;
		rep = NO_REPORT;
		if (first) begin
			left_cnt = region_len;
			pos_cnt = '0;
			cur_phase = P_TAG;
		end
		if (cur_phase == P_IDLE || cur_phase == P_ERROR)
			return 1'b0;
		here = pos_cnt;
		was_left = left_cnt;
		pos_cnt = pos_cnt + 1;
		if (left_cnt != 0)
			left_cnt = left_cnt - 1;
		case (cur_phase)
			P_TAG: begin
				if (was_left < 2)
					return fail_elem(b, ST_SHORT, rep);
				if (etag != 8'h00 && b != etag)
					return fail_elem(b, ST_TAG_MISMATCH, rep);
				if ((b & TAG_NUM_MASK) == TAG_NUM_MASK)
					return fail_elem(b, ST_HIGH_TAG, rep);
				held_tag = b;
				held_kind = kind;
				cur_phase = P_LEN0;
				return 1'b0;
			end
			P_LEN0: begin
				if ((b & LEN_LONG_BIT) == 8'h00) begin
					len_acc = {24'd0, b};
					return close_header(rep);
				end
				if (b == LEN_LONG_BIT)
					return fail_elem(held_tag, ST_INDEFINITE, rep);
				n_len = {24'd0, b & LEN_CNT_MASK};
				if (n_len > MAX_LENGTH_BYTES_DEF)
					return fail_elem(held_tag, ST_TOO_MANY_LEN, rep);
				if (n_len + 1 > was_left)
					return fail_elem(held_tag, ST_LEN_PAST_END, rep);
				len_bytes = n_len[2:0];
				len_acc = '0;
				cur_phase = P_LEN_FIRST;
				return 1'b0;
			end
			P_LEN_FIRST, P_LEN_REST: begin
				if (cur_phase == P_LEN_FIRST && b == ZERO_BYTE && len_bytes > 1)
					return fail_elem(held_tag, ST_NONMINIMAL, rep);
				len_acc = {len_acc[23:0], b};
				if (len_bytes != 0)
					len_bytes = len_bytes - 3'd1;
				cur_phase = P_LEN_REST;
				if (len_bytes == 0)
					return close_header(rep);
				return 1'b0;
			end
			P_VAL_FIRST: begin
				skip_cnt = (len_acc != 0) ? len_acc - 1 : 32'd0;
				if (held_kind == KIND_BITSTR) begin
					if (b != ZERO_BYTE)
						return fail_elem(held_tag, ST_BAD_BITSTR, rep);
					rep = '{held_tag, here + 32'd1, skip_cnt, ST_OK};
				end else if (b == ZERO_BYTE) begin
					// integer with a leading zero: strip it
					rep = '{held_tag, here + 32'd1, skip_cnt, ST_OK};
				end else begin
					rep = '{held_tag, here, len_acc, ST_OK};
				end
				if (skip_cnt == 0)
					goto_next_elem();
				else
					cur_phase = P_SKIP;
				return 1'b1;
			end
			P_SKIP: begin
				if (skip_cnt != 0)
					skip_cnt = skip_cnt - 1;
				if (skip_cnt == 0)
					goto_next_elem();
				return 1'b0;
			end
			default: begin
				cur_phase = P_ERROR;
				return 1'b0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- monitor

	// result beats are checked before the input beat of the same edge is modeled
	always @(posedge clk) begin
		elem_report_t want;
		elem_report_t got;
		bit has_rep;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.tag        = m_axis_tdata[7:0];
				got.val_offset = m_axis_tdata[39:8];
				got.val_length = m_axis_tdata[71:40];
				got.status     = status_t'(m_axis_tdata[75:72]);
				reports_seen++;
				if (got.status != ST_OK)
					error_reports++;
				if (pending_reports.size() == 0) begin
					$error("result beat with no report pending: tag %h status %0d",
						got.tag, got.status);
					fault_count++;
				end else begin
					want = pending_reports.pop_front();
					if (got.tag !== want.tag) begin
						$error("elem_tag: expected %h actual %h", want.tag, got.tag);
						fault_count++;
					end
					if (got.val_offset !== want.val_offset) begin
						$error("value_offset: expected %0d actual %0d",
							want.val_offset, got.val_offset);
						fault_count++;
					end
					if (got.val_length !== want.val_length) begin
						$error("value_length: expected %0d actual %0d",
							want.val_length, got.val_length);
						fault_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, got.status);
						fault_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				region_len = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				byte_beats++;
				has_rep = parse_byte(s_axis_tdata[7:0], s_axis_tuser[0],
					s_axis_tdata[15:8], s_axis_tuser[2:1], want);
				if (row_typed)
					pending_reports.push_back(row_want);
				else if (has_rep)
					pending_reports.push_back(want);
			end
		end
	end

	// ---------------------------------------------------------------- idling

	// receiver stalls in bursts, with stretches of no idling on either side
	always @(negedge clk) begin
		if (window_left == 0) begin
			window_left = $urandom_range(40, 300);
			rx_idle_on = ($urandom_range(0, 2) != 0);
			tx_idle_on = ($urandom_range(0, 2) != 0);
		end
		window_left = window_left - 1;
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= (stall_left == 0);
		end else if (rx_idle_on && !calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17);
			m_axis_tready <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// one byte beat; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] data, input logic first,
			input logic [7:0] etag, input logic [1:0] kind);
		if (tx_idle_on && !calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {etag, data};
		s_axis_tuser <= {kind, first};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// hold the stream until every pending report has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_region_len(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	// one region of mostly well-formed elements, cut off after span bytes
	task automatic send_region(input logic [31:0] span);
		logic [7:0]  elem_q [$];
		logic [7:0]  tag;
		logic [7:0]  etag;
		logic [7:0]  b;
		logic [1:0]  kind;
		logic [31:0] vlen;
		logic [31:0] sent;
		int          i;
		bit          garbled;
		sent = 0;
		garbled = ($urandom_range(0, 9) == 0);
		if (span == 0)
			span = 1;
		while (sent < span) begin
			elem_q.delete();
			tag = 8'($urandom_range(0, 255));
			if ((tag & TAG_NUM_MASK) == TAG_NUM_MASK && $urandom_range(0, 5) != 0)
				tag = tag ^ 8'h01;
			kind = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: etag = 8'h00;
				5, 6, 7, 8:    etag = tag;
				default:       etag = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 9))
				7, 8:    vlen = $urandom_range(6, 40);
				9:       vlen = $urandom_range(100, 300);
				default: vlen = $urandom_range(0, 5);
			endcase
			elem_q.push_back(tag);
			// length header: short or long form, now and then a broken one
			if (garbled || $urandom_range(0, 29) == 0) begin
				case ($urandom_range(0, 3))
					0: elem_q.push_back(LEN_LONG_BIT);
					1: elem_q.push_back(8'($urandom_range(8'h85, 8'hFF)));
					2: begin
						elem_q.push_back(8'h82);
						elem_q.push_back(ZERO_BYTE);
						elem_q.push_back(vlen[7:0]);
					end
					default: begin
						elem_q.push_back(8'h84);
						repeat (4) elem_q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end else if (vlen < 128 && $urandom_range(0, 3) != 0) begin
				elem_q.push_back(vlen[7:0]);
			end else if (vlen < 256) begin
				elem_q.push_back(8'h81);
				elem_q.push_back(vlen[7:0]);
			end else begin
				elem_q.push_back(8'h82);
				elem_q.push_back(vlen[15:8]);
				elem_q.push_back(vlen[7:0]);
			end
			for (i = 0; i < vlen; i++) begin
				b = 8'($urandom_range(0, 255));
				if (i == 0 && kind == KIND_INTEGER && $urandom_range(0, 1) == 0)
					b = ZERO_BYTE;
				if (i == 0 && kind == KIND_BITSTR && $urandom_range(0, 5) != 0)
					b = ZERO_BYTE;
				elem_q.push_back(b);
			end
			// feed the element, with stray corruption and rare restarts
			for (i = 0; i < elem_q.size() && sent < span; i++) begin
				b = elem_q[i];
				if ($urandom_range(0, garbled ? 3 : 49) == 0)
					b = 8'($urandom_range(0, 255));
				send_byte(b, sent == 0 || $urandom_range(0, 299) == 0,
					(i == 0) ? etag : 8'($urandom_range(0, 255)),
					(i == 0) ? kind : 2'($urandom_range(0, 3)));
				sent++;
			end
		end
		// trailing bytes past the region end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
	endtask

	// main sequence
	initial begin
		logic [31:0] setting;
		int unsigned phase_no;
		int unsigned budget_end;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].act == ROW_CFG) begin
				settle();
				write_region_len(directed_rows[i].cfg_value);
			end else begin
				row_typed = directed_rows[i].typed;
				row_want = directed_rows[i].want;
				send_byte(directed_rows[i].data, directed_rows[i].first,
					directed_rows[i].etag, directed_rows[i].kind);
			end
		end
		row_typed = 1'b0;

		// random regions under a sequence of region_length settings
		phase_no = 0;
		while (byte_beats < 780) begin
			case (phase_no)
				1:       setting = 32'd0;
				2:       setting = 32'hFFFF_FFFF;
				3:       setting = 32'd1;
				4:       setting = $urandom_range(256, 400);
				5:       setting = 32'd2;
				6:       setting = 32'd3;
				default: setting = $urandom_range(8, 80);
			endcase
			settle();
			write_region_len(setting);
			budget_end = byte_beats + 80;
			while (byte_beats < budget_end && byte_beats < 780) begin
				calm = (byte_beats >= 680);
				send_region((setting > 600) ? 32'($urandom_range(20, 64)) : setting);
			end
			phase_no++;
		end

		// drain and finish
		settle();
		repeat (8) @(negedge clk);
		$display("covered %0d byte beats across %0d region_length settings",
			byte_beats, settings_written);
		$display("checked %0d result beats, %0d of them error reports",
			reports_seen, error_reports);
		if (fault_count == 0 && pending_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
